// ===== hdl/ihex_pkg.sv =====
// Shared types, codes and helper functions for the Intel HEX record parser.
// Depends on nothing; every other file of the block imports it.
package ihex_pkg;

	// Widest memory address that a record may reach, in bits.
	localparam int ADDR_BITS = 16;
	localparam int ADDR_W    = 16;
	localparam int SUM_W     = ADDR_W + 1;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	// Where the parser stands within a line of text.
	typedef enum logic [2:0] {
		PH_WAIT,
		PH_LEN,
		PH_AH,
		PH_AL,
		PH_TYPE,
		PH_DATA,
		PH_CSUM,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		K_WRITE = 2'd0,
		K_DONE  = 2'd1,
		K_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		E_COLON = 2'd0,
		E_DIGIT = 2'd1,
		E_RANGE = 2'd2,
		E_CSUM  = 2'd3
	} err_t;

	// Everything the parser remembers between characters.
	typedef struct packed {
		phase_t              phase;
		logic [3:0]          first_nibble;
		logic                second_due;
		logic [7:0]          rec_len;
		logic [ADDR_W-1:0]   rec_addr;
		logic [7:0]          offset;
		logic [7:0]          sum;
		logic [7:0]          cur_type;
	} parse_state_t;

	// One result item as it leaves the parser.
	typedef struct packed {
		kind_t               kind;
		logic [ADDR_W-1:0]   addr;
		logic [7:0]          data;
		logic [7:0]          rec_kind;
		err_t                err;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	// Decodes one ASCII hex digit in either case.
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.ok    = 1'b1;
		d.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.value = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			d.value = c[3:0] + 4'd9;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

// ===== hdl/ihex_step.sv =====
// Per-character next-state and result logic of the Intel HEX parser.
// Depends on ihex_pkg for the state, result and code types.
module ihex_step (
	input  ihex_pkg::parse_state_t cur,
	input  logic [7:0]             text_char,
	output ihex_pkg::parse_state_t nxt,
	output logic                   res_valid,
	output ihex_pkg::result_t      res
);
	import ihex_pkg::*;

	hex_digit_t        dig;
	logic              is_lf;
	logic [7:0]        byte_val;
	logic [7:0]        sum_plus;
	logic [7:0]        offset_inc;
	logic [SUM_W-1:0]  end_addr;
	logic [SUM_W-1:0]  addr_limit;
	logic [ADDR_W-1:0] data_addr;

	// Byte assembly, running sum and address arithmetic shared by all phases.
	assign dig        = hex_decode(text_char);
	assign is_lf      = (text_char == CHAR_LF);
	assign byte_val   = {cur.first_nibble, dig.value};
	assign sum_plus   = cur.sum + byte_val;
	assign offset_inc = cur.offset + 8'd1;
	assign end_addr   = {1'b0, cur.rec_addr} + SUM_W'(cur.rec_len);
	assign addr_limit = SUM_W'(1) << ADDR_BITS;
	assign data_addr  = cur.rec_addr + ADDR_W'(cur.offset);

	// Phase sequencing and the single possible result of one character.
	always_comb begin
		nxt          = cur;
		res_valid    = 1'b0;
		res.kind     = K_ERROR;
		res.addr     = '0;
		res.data     = 8'd0;
		res.rec_kind = 8'd0;
		res.err      = E_COLON;

		case (cur.phase)
			PH_SKIP: begin
				if (is_lf) begin
					nxt.phase = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (text_char == CHAR_COLON) begin
					nxt.phase        = PH_LEN;
					nxt.first_nibble = 4'd0;
					nxt.second_due   = 1'b0;
					nxt.rec_len      = 8'd0;
					nxt.rec_addr     = '0;
					nxt.offset       = 8'd0;
					nxt.sum          = 8'd0;
					nxt.cur_type     = 8'd0;
				end else begin
					nxt.phase = is_lf ? PH_WAIT : PH_SKIP;
					res_valid = 1'b1;
					res.err   = E_COLON;
				end
			end
			default: begin
				if (!dig.ok) begin
					// A stray character inside a record ends it.
					nxt.second_due = 1'b0;
					nxt.phase      = is_lf ? PH_WAIT : PH_SKIP;
					res_valid      = 1'b1;
					res.rec_kind   = cur.cur_type;
					res.err        = E_DIGIT;
				end else if (!cur.second_due) begin
					nxt.first_nibble = dig.value;
					nxt.second_due   = 1'b1;
				end else begin
					nxt.second_due = 1'b0;
					case (cur.phase)
						PH_LEN: begin
							nxt.rec_len = byte_val;
							nxt.sum     = sum_plus;
							nxt.phase   = PH_AH;
						end
						PH_AH: begin
							nxt.rec_addr = {byte_val, (ADDR_W-8)'(0)};
							nxt.sum      = sum_plus;
							nxt.phase    = PH_AL;
						end
						PH_AL: begin
							nxt.rec_addr = {cur.rec_addr[ADDR_W-1:8], byte_val};
							nxt.sum      = sum_plus;
							nxt.phase    = PH_TYPE;
						end
						PH_TYPE: begin
							nxt.cur_type = byte_val;
							nxt.sum      = sum_plus;
							if (end_addr > addr_limit) begin
								nxt.phase    = PH_SKIP;
								res_valid    = 1'b1;
								res.rec_kind = byte_val;
								res.err      = E_RANGE;
							end else begin
								nxt.offset = 8'd0;
								nxt.phase  = (cur.rec_len == 8'd0) ? PH_CSUM : PH_DATA;
							end
						end
						PH_DATA: begin
							nxt.sum    = sum_plus;
							nxt.offset = offset_inc;
							if (offset_inc == cur.rec_len) begin
								nxt.phase = PH_CSUM;
							end
							res_valid    = 1'b1;
							res.kind     = K_WRITE;
							res.addr     = data_addr;
							res.data     = byte_val;
							res.rec_kind = cur.cur_type;
						end
						default: begin
							// Checksum: the byte sum of the record must come to zero.
							nxt.phase    = PH_SKIP;
							res_valid    = 1'b1;
							res.rec_kind = cur.cur_type;
							if (sum_plus == 8'd0) begin
								res.kind = K_DONE;
							end else begin
								res.err = E_CSUM;
							end
						end
					endcase
				end
			end
		endcase
	end

endmodule

// ===== hdl/intel_hex_record_parser.sv =====
// Top level of the Intel HEX record parser: input stage, parser state and result register.
// Depends on ihex_pkg and ihex_step.
//
// The parser takes one ASCII character per item and gives at most one result item
// for it: a data byte write, a record-done notice with a good checksum, or an error.
// It sustains one character per clock cycle while the consumer takes its results; a
// result that out_ready does not take holds the flow once the input stage is full. An
// accepted character passes through the input stage into the result register, and that
// register drives the outputs directly. The input stage and the result register
// together let one further character be taken while a result waits for the
// consumer. After reset the parser waits for a ':'.
module intel_hex_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] write_address,
	output logic [7:0]  write_data,
	output logic [7:0]  record_kind,
	output logic [1:0]  error_code
);
	import ihex_pkg::*;

	logic         valid_s1;
	logic [7:0]   char_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         res_valid;
	result_t      res;
	logic         out_valid_q;
	result_t      res_q;
	logic         advance;

	// The input stage moves on whenever the result register is free or emptying.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input stage holding one accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= text_char;
		end
	end

	ihex_step u_step (
		.cur       (state_q),
		.text_char (char_s1),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// Parser state advances once per character leaving the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_WAIT, first_nibble: 4'd0, second_due: 1'b0,
				rec_len: 8'd0, rec_addr: '0, offset: 8'd0, sum: 8'd0, cur_type: 8'd0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	// Output ports.
	assign out_valid     = out_valid_q;
	assign kind          = res_q.kind;
	assign write_address = res_q.addr;
	assign write_data    = res_q.data;
	assign record_kind   = res_q.rec_kind;
	assign error_code    = res_q.err;

endmodule
